[sv/rlpd_pkg.sv]
// rlpd_pkg: types, constants and helpers shared by the rate limited dispatch block
// no dependencies; imported by rlpd_ram users, rlpd_scan and the top level

package rlpd_pkg;

  localparam int QueueDepthDefault = 16;
  localparam int PriorityLevels    = 4;
  localparam logic [6:0] ResetRate = 7'd3;

  localparam logic MODE_ENQUEUE  = 1'b0;
  localparam logic MODE_DISPATCH = 1'b1;

  localparam logic STATUS_SENT     = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  // one input item
  typedef struct packed {
    logic        mode;
    logic [15:0] request_id;
    logic [1:0]  priority_req;
    logic [31:0] now_second;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic        status;
    logic [15:0] out_request_id;
    logic [1:0]  out_priority;
    logic [4:0]  remaining;
    logic        last;
  } result_t;

  // one stored queue entry
  typedef struct packed {
    logic [15:0] id;
    logic [1:0]  pri;
    logic [31:0] age;
  } entry_t;

  // scan unit control from the sequencer
  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctl_t;

  // clamp a priority to the top level
  function automatic logic [1:0] sat_priority(input logic [1:0] pri);
    logic [1:0] res;
    res = pri;
    if (int'(pri) > PriorityLevels - 1) begin
      res = 2'(PriorityLevels - 1);
    end
    return res;
  endfunction

endpackage

[sv/rlpd_ram.sv]
// rlpd_ram: generic single write port, single read port ram with registered read
// no dependencies

module rlpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/rlpd_scan.sv]
// rlpd_scan: shared compare unit, keeps the best entry seen during one queue sweep
// depends on rlpd_pkg

module rlpd_scan #(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  rlpd_pkg::scan_ctl_t       ctl,
  input  logic                      cand_valid,
  input  rlpd_pkg::entry_t          cand,
  input  logic [$clog2(DEPTH)-1:0]  cand_slot,
  input  logic [31:0]               counter,
  output rlpd_pkg::entry_t          best,
  output logic [$clog2(DEPTH)-1:0]  best_slot
);
  import rlpd_pkg::*;

  logic        has_best;
  logic [31:0] best_wait;
  logic [31:0] cand_wait;
  logic        better;

  // older entries have a larger distance from the enqueue counter
  assign cand_wait = counter - cand.age;
  assign better = cand_valid &&
                  (!has_best || (cand.pri > best.pri) ||
                   ((cand.pri == best.pri) && (cand_wait > best_wait)));

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      has_best <= 1'b0;
    end else if (ctl.step && better) begin
      has_best  <= 1'b1;
      best      <= cand;
      best_wait <= cand_wait;
      best_slot <= cand_slot;
    end
  end

endmodule

[sv/rate_limited_priority_dispatch.sv]
// rate_limited_priority_dispatch: top level, sequencer, slot state and result register
// depends on rlpd_pkg, rlpd_ram and rlpd_scan
//
// Usage: an item (cmd) is accepted on a clock edge with start high and busy low.
// mode enqueue stores request_id and priority_req in the first free slot; the
// slot search walks the valid bits one per cycle. A full queue gives one
// rejected result with last set. mode dispatch compares now_second with the
// open window in the accept cycle, opens a new window with the full
// max_per_second budget if it differs, and sends up to the unused budget.
// Each sent request costs one sweep of the shared compare unit over all slots
// through the registered entry ram, in S_SCAN and S_LAST, and its result is
// sent from S_EMIT. A dispatch with nothing to send gives no result. Results
// appear on result for one cycle with strobe high; the receiver cannot stall
// them. cfg_we writes max_per_second; the user must write it only while the
// block is idle, and the block itself does not enforce this. Reset (rst,
// synchronous) empties the queue, zeroes the enqueue counter and window, and
// restores max_per_second to 3.

module rate_limited_priority_dispatch #(
  parameter int QUEUE_DEPTH = rlpd_pkg::QueueDepthDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  rlpd_pkg::cmd_t    cmd,
  output rlpd_pkg::result_t result,
  output logic              strobe,
  input  logic              cfg_we,
  input  logic [6:0]        cfg_data
);
  import rlpd_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LastSlot = AW'(QUEUE_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ,
    S_SCAN,
    S_LAST,
    S_EMIT
  } state_t;

  state_t state;
  logic [AW-1:0]          idx;
  logic                   cand_live;
  logic [AW-1:0]          cand_slot;
  logic [QUEUE_DEPTH-1:0] valid;
  logic [31:0]            counter;
  logic [CW-1:0]          count;
  logic [31:0]            window_second;
  logic [6:0]             window_used;
  logic [6:0]             max_per_second;
  logic [6:0]             left;
  logic [15:0]            req_id;
  logic [1:0]             req_pri;

  logic      ram_we;
  entry_t    ram_wdata;
  entry_t    ram_rdata;
  scan_ctl_t scan_ctl;
  entry_t    best;
  logic [AW-1:0] best_slot;

  logic [6:0] waiting;
  logic [6:0] avail;
  logic [6:0] send_n;
  logic [CW-1:0] count_dec;

  assign busy = (state != S_IDLE);

  // budget for a dispatch item, worked out in its accept cycle
  assign waiting = 7'(count);
  always_comb begin
    if (cmd.now_second == window_second) begin
      avail = (max_per_second > window_used) ? (max_per_second - window_used) : 7'd0;
    end else begin
      avail = max_per_second;
    end
    send_n = (avail > waiting) ? waiting : avail;
  end

  assign count_dec = count - CW'(1);

  // entry store
  assign ram_we    = (state == S_ENQ) && !valid[idx];
  assign ram_wdata = '{id: req_id, pri: req_pri, age: counter};

  rlpd_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx),
    .wdata(ram_wdata),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  // shared compare unit
  always_comb begin
    scan_ctl.step  = cand_live;
    scan_ctl.clear = ((state == S_IDLE) && start && (cmd.mode == MODE_DISPATCH)) ||
                     (state == S_EMIT);
  end

  rlpd_scan #(
    .DEPTH(QUEUE_DEPTH)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctl       (scan_ctl),
    .cand_valid(valid[cand_slot]),
    .cand      (ram_rdata),
    .cand_slot (cand_slot),
    .counter   (counter),
    .best      (best),
    .best_slot (best_slot)
  );

  // sequencer, slot state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      idx            <= '0;
      cand_live      <= 1'b0;
      valid          <= '0;
      counter        <= '0;
      count          <= '0;
      window_second  <= '0;
      window_used    <= '0;
      max_per_second <= ResetRate;
      left           <= '0;
      strobe         <= 1'b0;
    end else begin
      strobe    <= 1'b0;
      cand_live <= (state == S_SCAN);
      cand_slot <= idx;
      if (cfg_we) begin
        max_per_second <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          idx <= '0;
          if (start) begin
            if (cmd.mode == MODE_ENQUEUE) begin
              req_id  <= cmd.request_id;
              req_pri <= sat_priority(cmd.priority_req);
              state   <= S_ENQ;
            end else begin
              if (cmd.now_second == window_second) begin
                window_used <= window_used + send_n;
              end else begin
                window_second <= cmd.now_second;
                window_used   <= send_n;
              end
              left <= send_n;
              if (send_n != 7'd0) begin
                state <= S_SCAN;
              end
            end
          end
        end
        S_ENQ: begin
          if (!valid[idx]) begin
            valid[idx] <= 1'b1;
            counter    <= counter + 32'd1;
            count      <= count + CW'(1);
            state      <= S_IDLE;
          end else if (idx == LastSlot) begin
            result.status         <= STATUS_REJECTED;
            result.out_request_id <= req_id;
            result.out_priority   <= req_pri;
            result.remaining      <= 5'(count);
            result.last           <= 1'b1;
            strobe                <= 1'b1;
            state                 <= S_IDLE;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        S_SCAN: begin
          if (idx == LastSlot) begin
            state <= S_LAST;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        S_LAST: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          valid[best_slot]      <= 1'b0;
          count                 <= count_dec;
          left                  <= left - 7'd1;
          result.status         <= STATUS_SENT;
          result.out_request_id <= best.id;
          result.out_priority   <= best.pri;
          result.remaining      <= 5'(count_dec);
          result.last           <= (left == 7'd1);
          strobe                <= 1'b1;
          idx                   <= '0;
          state                 <= (left == 7'd1) ? S_IDLE : S_SCAN;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // occupancy count tracks the valid bits
  assert property (@(posedge clk) disable iff (rst) $countones(valid) == int'(count))
    else $error("occupancy count out of step with valid bits");

  // the entry picked for sending is a live one
  assert property (@(posedge clk) disable iff (rst) (state == S_EMIT) |-> valid[best_slot])
    else $error("dispatch picked an empty slot");

  // every finished sweep puts out a sent result
  assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |=> strobe && (result.status == STATUS_SENT))
    else $error("sweep finished without a sent result");

  // the window never spends past its budget unless the budget was lowered
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) && start && (cmd.mode == MODE_DISPATCH) && !cfg_we |=>
      (window_used <= $past(max_per_second)) || (window_used == $past(window_used)))
    else $error("window budget overrun");

endmodule

[dv/rate_limited_priority_dispatch_tb.sv]
// rate_limited_priority_dispatch_tb: self-checking bench for the rate limited dispatch queue
// drives enqueue and dispatch items, predicts every result and compares field by field
// depends on rlpd_pkg and rate_limited_priority_dispatch

module rate_limited_priority_dispatch_tb;
  import rlpd_pkg::*;

  localparam int Depth      = QueueDepthDefault;
  localparam int CycleLimit = 400000;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       start    = 1'b0;
  logic       busy;
  cmd_t       cmd      = '0;
  result_t    result;
  logic       strobe;
  logic       cfg_we   = 1'b0;
  logic [6:0] cfg_data = 7'd0;

  // sender idle percentage and the second that dispatch items walk along
  int unsigned idle_pct = 0;
  logic [31:0] cur_sec  = 32'd0;
  int          cycle_count = 0;

  // queue predictor and store of expected results
  class dispatch_checker;
    logic [15:0] slot_id   [Depth];
    logic [1:0]  slot_pri  [Depth];
    logic [31:0] slot_age  [Depth];
    bit          slot_used [Depth];
    logic [31:0] stamp;
    logic [31:0] window_sec;
    int          window_sent;
    logic [6:0]  rate;
    result_t     pending_results[$];
    int          errors;

    function new();
      foreach (slot_used[i]) begin
        slot_used[i] = 1'b0;
      end
      stamp       = 32'd0;
      window_sec  = 32'd0;
      window_sent = 0;
      rate        = ResetRate;
      errors      = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function int waiting_count();
      int n;
      n = 0;
      foreach (slot_used[i]) begin
        if (slot_used[i]) n++;
      end
      return n;
    endfunction

    // highest priority, then longest wait measured from the enqueue stamp
    function int best_slot();
      int best;
      logic [31:0] best_wait;
      logic [31:0] w;
      best = -1;
      best_wait = 32'd0;
      for (int i = 0; i < Depth; i++) begin
        if (slot_used[i]) begin
          w = stamp - slot_age[i];
          if (best < 0 || slot_pri[i] > slot_pri[best] ||
              (slot_pri[i] == slot_pri[best] && w > best_wait)) begin
            best = i;
            best_wait = w;
          end
        end
      end
      return best;
    endfunction

    function void note_cmd(cmd_t c);
      int waiting;
      int n;
      int b;
      bit placed;
      logic [1:0] p;
      result_t r;
      waiting = waiting_count();
      if (c.mode == MODE_ENQUEUE) begin
        p = c.priority_req;
        if (int'(p) > PriorityLevels - 1) p = 2'(PriorityLevels - 1);
        placed = 1'b0;
        // first free slot takes the request
        for (int i = 0; i < Depth; i++) begin
          if (!placed && !slot_used[i]) begin
            slot_id[i]   = c.request_id;
            slot_pri[i]  = p;
            slot_age[i]  = stamp;
            slot_used[i] = 1'b1;
            stamp        = stamp + 32'd1;
            placed       = 1'b1;
          end
        end
        // full queue rejects the item
        if (!placed) begin
          r.status         = STATUS_REJECTED;
          r.out_request_id = c.request_id;
          r.out_priority   = p;
          r.remaining      = 5'(waiting);
          r.last           = 1'b1;
          pending_results.push_back(r);
        end
      end else begin
        n = 0;
        if (c.now_second == window_sec) begin
          if (int'(rate) > window_sent) begin
            n = int'(rate) - window_sent;
            if (n > waiting) n = waiting;
            window_sent += n;
          end
        end else begin
          // new second opens a fresh window
          n = int'(rate);
          if (n > waiting) n = waiting;
          window_sec  = c.now_second;
          window_sent = n;
        end
        for (int k = 0; k < n; k++) begin
          b = best_slot();
          slot_used[b] = 1'b0;
          waiting--;
          r.status         = STATUS_SENT;
          r.out_request_id = slot_id[b];
          r.out_priority   = slot_pri[b];
          r.remaining      = 5'(waiting);
          r.last           = (k == n - 1);
          pending_results.push_back(r);
        end
      end
    endfunction

    task check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result id %h with none expected", got.out_request_id));
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status)
          report($sformatf("status %b, expected %b", got.status, want.status));
        if (got.out_request_id != want.out_request_id)
          report($sformatf("out_request_id %h, expected %h",
                           got.out_request_id, want.out_request_id));
        if (got.out_priority != want.out_priority)
          report($sformatf("out_priority %0d, expected %0d",
                           got.out_priority, want.out_priority));
        if (got.remaining != want.remaining)
          report($sformatf("remaining %0d, expected %0d", got.remaining, want.remaining));
        if (got.last != want.last)
          report($sformatf("last %b, expected %b", got.last, want.last));
      end
    endtask

    task drain_check();
      if (pending_results.size() != 0)
        report($sformatf("%0d results never arrived", pending_results.size()));
    endtask
  endclass

  dispatch_checker chk = new();

  rate_limited_priority_dispatch #(
    .QUEUE_DEPTH(Depth)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .result  (result),
    .strobe  (strobe),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // result monitor
  always @(posedge clk) begin
    if (!rst && strobe) chk.check_result(result);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("rate_limited_priority_dispatch_tb NOT OK");
      $finish;
    end
  end

  function automatic cmd_t mk(logic m, logic [15:0] id, logic [1:0] p, logic [31:0] s);
    cmd_t c;
    c.mode         = m;
    c.request_id   = id;
    c.priority_req = p;
    c.now_second   = s;
    return c;
  endfunction

  // mostly enqueues; dispatches stay in the window, step a second or jump anywhere
  function automatic cmd_t random_cmd();
    cmd_t c;
    int roll;
    c.request_id   = 16'($urandom);
    c.priority_req = 2'($urandom_range(3));
    c.now_second   = $urandom;
    c.mode         = ($urandom_range(99) < 35) ? MODE_DISPATCH : MODE_ENQUEUE;
    if (c.mode == MODE_DISPATCH) begin
      roll = $urandom_range(99);
      if (roll < 30) cur_sec = cur_sec + 32'd1;
      else if (roll < 40) cur_sec = $urandom;
      c.now_second = cur_sec;
    end
    return c;
  endfunction

  // hand one item over, with a random gap before it
  task automatic send_item(input cmd_t c);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    chk.note_cmd(c);
  endtask

  // all results in and the block quiet
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (busy || chk.pending_results.size() != 0);
    repeat (Depth + 4) @(posedge clk);
  endtask

  task automatic set_rate(input logic [6:0] v);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    chk.rate = v;
  endtask

  task automatic random_phase(input int count, input int unsigned pct, input logic [6:0] v);
    set_rate(v);
    idle_pct = pct;
    repeat (count) send_item(random_cmd());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    idle_pct = 7;

    // dispatch in the reset window with nothing waiting
    send_item(mk(MODE_DISPATCH, 16'hFFFF, 2'd3, 32'd0));
    // mixed priorities, with a tie at the top
    send_item(mk(MODE_ENQUEUE, 16'h0000, 2'd0, 32'hFFFF_FFFF));
    send_item(mk(MODE_ENQUEUE, 16'hFFFF, 2'd3, 32'd0));
    send_item(mk(MODE_ENQUEUE, 16'h0005, 2'd3, 32'h5555_5555));
    send_item(mk(MODE_ENQUEUE, 16'hAAAA, 2'd2, 32'hAAAA_AAAA));
    // reset window budget, then spent budget, then a new window at the top second
    send_item(mk(MODE_DISPATCH, 16'h1234, 2'd1, 32'd0));
    send_item(mk(MODE_DISPATCH, 16'h0000, 2'd0, 32'd0));
    send_item(mk(MODE_DISPATCH, 16'h0000, 2'd0, 32'hFFFF_FFFF));
    // fill every slot, then one rejected request
    for (int i = 0; i < Depth; i++) begin
      send_item(mk(MODE_ENQUEUE, 16'($urandom), 2'(i), $urandom));
    end
    send_item(mk(MODE_ENQUEUE, 16'h7FFF, 2'd3, 32'd0));
    cur_sec = 32'hFFFF_FFFF;

    // budget settings; 1 and 5 each lower the rate set before them, possibly under what the window already used
    random_phase(10, 7, 7'd0);
    random_phase(19, 7, 7'd64);
    random_phase(19, 87, 7'd1);
    random_phase(19, 0, 7'd63);
    random_phase(18, 0, 7'd5);

    wait_idle();
    chk.drain_check();
    if (chk.errors == 0) begin
      $display("rate_limited_priority_dispatch_tb OK");
    end else begin
      $display("rate_limited_priority_dispatch_tb NOT OK");
    end
    $finish;
  end

endmodule
